### design/gaussian_blur_5x5_macros.svh
// Assertion macros for the port-level checker of the 5x5 Gaussian blur.
// Each macro expects signals named clk and arst_n in the scope that uses it.
// No other dependencies.
`ifndef GAUSSIAN_BLUR_5X5_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GB_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/gblur_pkg.sv
// Package for the 5x5 Gaussian blur: sizes, payload structs, register indexes
// and the fixed-point weight table. It depends on nothing else.
`default_nettype none

package gblur_pkg;

	// Sizes of the line stores, the window and the position counters.
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 4096;
	localparam int TAPS       = 5;
	localparam int LINES      = TAPS - 1;
	localparam int HALF       = TAPS / 2;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 12;
	localparam int CUR_W_W    = COL_W + 1;
	localparam int DRAIN_W    = CUR_W_W + 1;

	// Configuration register widths, index width and reset values.
	localparam int CFG_W_W    = 10;
	localparam int CFG_H_W    = 13;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int RESET_FRAME_WIDTH  = 512;
	localparam int RESET_FRAME_HEIGHT = 512;
	localparam int MIN_SIZE   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Request action codes.
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Arithmetic: Q0.16 weights, 25-bit accumulation, round to nearest.
	localparam int WGT_W   = 14;
	localparam int FRAC_W  = 16;
	localparam int ACC_W   = 25;
	localparam int PIX_MAX = 255;

	localparam logic [WGT_W-1:0] WEIGHT [TAPS][TAPS] = '{
		'{14'd195,  14'd872,  14'd1438,  14'd872,  14'd195},
		'{14'd872,  14'd3908, 14'd6444,  14'd3908, 14'd872},
		'{14'd1438, 14'd6444, 14'd10624, 14'd6444, 14'd1438},
		'{14'd872,  14'd3908, 14'd6444,  14'd3908, 14'd872},
		'{14'd195,  14'd872,  14'd1438,  14'd872,  14'd195}
	};

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] pixel_value;
	} pix_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] blurred_pixel;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             frame_done;
	} blur_rsp_t;

endpackage

`default_nettype wire

### design/gblur_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module gblur_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Registered read; ports must not share an address in a cycle (unchecked).
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### design/gaussian_blur_5x5.sv
// A request that completes a window is registered in the input, window, row-sum and output
// stages before its result shows; it comes two rows plus two pixels after the center pixel.
// Throughput: one request per cycle unless the output stalls; four stages (input, window,
// row sums, output) each advance whenever the stage after them is empty or moving.
// Reset clears all counters and valid bits and restores the sizes at once; line stores are not cleared.
`default_nettype none

module gaussian_blur_5x5 (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gblur_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [gblur_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                 pix_valid,
	output logic                                 pix_ready,
	input  gblur_pkg::pix_req_t                  pix,
	output logic                                 blur_valid,
	input  logic                                 blur_ready,
	output gblur_pkg::blur_rsp_t                 blur
);
	import gblur_pkg::*;

	// Configuration and latched frame sizes.
	logic [CFG_W_W-1:0] frame_width_q;
	logic [CFG_H_W-1:0] frame_height_q;
	logic [CUR_W_W-1:0] cur_w_q;
	logic [CFG_H_W-1:0] cur_h_q;
	logic [CUR_W_W-1:0] w_clamp, w_eff;
	logic [CFG_H_W-1:0] h_clamp, h_eff;

	// Position counters.
	logic [ROW_W-1:0]   in_row_q, emit_row_q;
	logic [COL_W-1:0]   in_col_q, emit_col_q;
	logic [DRAIN_W-1:0] drain_left_q;

	// Request decode.
	logic               take, flush, is_pix, first, casc, emit, last_pix, done;
	logic [CUR_W_W-1:0] in_col_inc, emit_col_inc;
	logic               in_wrap, emit_wrap;
	logic [TAPS-1:0]    row_ok, col_ok;

	// Pipeline control.
	logic v1_s1, v2_s2, v3_s3, out_valid_q;
	logic ld_out, adv3, adv2;

	// Stage 1 payload.
	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1, done_s1;
	logic [TAPS-1:0]  row_ok_s1, col_ok_s1;
	logic [ROW_W-1:0] orow_s1;
	logic [COL_W-1:0] ocol_s1;

	// Line store and the column entering the window.
	logic [LINES*PIX_W-1:0] line_rd, line_wr;
	logic [PIX_W-1:0]       col_new [TAPS];

	// Stage 2: window and output metadata.
	logic [PIX_W-1:0] win_s2 [TAPS][TAPS];
	logic [TAPS-1:0]  row_ok_s2, col_ok_s2;
	logic [ROW_W-1:0] orow_s2;
	logic [COL_W-1:0] ocol_s2;
	logic             done_s2;
	logic [ACC_W-1:0] rowsum [TAPS];

	// Stage 3: row sums.
	logic [ACC_W-1:0] rowsum_s3 [TAPS];
	logic [ROW_W-1:0] orow_s3;
	logic [COL_W-1:0] ocol_s3;
	logic             done_s3;
	logic [ACC_W-1:0] total;
	logic [ACC_W-FRAC_W-1:0] scaled;
	logic [PIX_W-1:0] sat;

	blur_rsp_t blur_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W_W'(RESET_FRAME_WIDTH);
			frame_height_q <= CFG_H_W'(RESET_FRAME_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[CFG_W_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[CFG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the written sizes into the supported range.
	always_comb begin
		if (32'(frame_width_q) < MIN_SIZE) begin
			w_clamp = CUR_W_W'(MIN_SIZE);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_clamp = CUR_W_W'(MAX_WIDTH);
		end else begin
			w_clamp = CUR_W_W'(frame_width_q);
		end
		if (32'(frame_height_q) < MIN_SIZE) begin
			h_clamp = CFG_H_W'(MIN_SIZE);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_clamp = CFG_H_W'(MAX_HEIGHT);
		end else begin
			h_clamp = frame_height_q;
		end
	end

	// Handshake: each stage moves when the one after it is empty or moving.
	assign ld_out    = v3_s3 && (!out_valid_q || blur_ready);
	assign adv3      = !v3_s3 || ld_out;
	assign adv2      = !v2_s2 || adv3;
	assign pix_ready = !v1_s1 || adv2;
	assign take      = pix_valid && pix_ready;

	// Decode the request against the current frame position.
	always_comb begin
		flush    = drain_left_q != '0;
		is_pix   = pix.action == ACT_PIXEL;
		first    = !flush && in_row_q == '0 && in_col_q == '0;
		w_eff    = first ? w_clamp : cur_w_q;
		h_eff    = first ? h_clamp : cur_h_q;
		casc     = flush || is_pix;
		emit     = flush || (is_pix && (in_row_q > ROW_W'(2) ||
			(in_row_q == ROW_W'(2) && in_col_q >= COL_W'(2))));
		last_pix = !flush && is_pix && {1'b0, in_row_q} == h_eff - CFG_H_W'(1) &&
			{1'b0, in_col_q} == w_eff - CUR_W_W'(1);
		done     = flush && drain_left_q == DRAIN_W'(1);

		in_col_inc   = {1'b0, in_col_q} + CUR_W_W'(1);
		in_wrap      = in_col_inc >= w_eff;
		emit_col_inc = {1'b0, emit_col_q} + CUR_W_W'(1);
		emit_wrap    = emit_col_inc >= w_eff;

		// Taps outside the frame are dropped from the sum.
		row_ok[0] = emit_row_q >= ROW_W'(2);
		row_ok[1] = emit_row_q >= ROW_W'(1);
		row_ok[2] = {1'b0, emit_row_q} < h_eff;
		row_ok[3] = {1'b0, emit_row_q} + CFG_H_W'(1) < h_eff;
		row_ok[4] = {1'b0, emit_row_q} + CFG_H_W'(2) < h_eff;
		col_ok[0] = emit_col_q >= COL_W'(2);
		col_ok[1] = emit_col_q >= COL_W'(1);
		col_ok[2] = {1'b0, emit_col_q} < w_eff;
		col_ok[3] = {1'b0, emit_col_q} + CUR_W_W'(1) < w_eff;
		col_ok[4] = {1'b0, emit_col_q} + CUR_W_W'(2) < w_eff;
	end

	// Position counters, frame size latch and flush count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_w_q      <= CUR_W_W'(RESET_FRAME_WIDTH);
			cur_h_q      <= CFG_H_W'(RESET_FRAME_HEIGHT);
			in_row_q     <= '0;
			in_col_q     <= '0;
			emit_row_q   <= '0;
			emit_col_q   <= '0;
			drain_left_q <= '0;
		end else if (take && casc) begin
			if (first) begin
				cur_w_q <= w_clamp;
				cur_h_q <= h_clamp;
			end
			if (done) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				emit_row_q <= '0;
				emit_col_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				if (emit) begin
					if (emit_wrap) begin
						emit_col_q <= '0;
						emit_row_q <= emit_row_q + ROW_W'(1);
					end else begin
						emit_col_q <= emit_col_inc[COL_W-1:0];
					end
				end
			end
			if (flush) begin
				drain_left_q <= drain_left_q - DRAIN_W'(1);
			end else if (last_pix) begin
				drain_left_q <= {w_eff, 1'b0} + DRAIN_W'(2);
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pix_ready) begin
				v1_s1 <= take && casc;
			end
			if (adv2) begin
				v2_s2 <= v1_s1 && emit_s1;
			end
			if (adv3) begin
				v3_s3 <= v2_s2;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (blur_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1 payload: pixel, store column and the output it completes.
	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1    <= pix.pixel_value;
			col_s1    <= in_col_q;
			emit_s1   <= emit;
			done_s1   <= done;
			row_ok_s1 <= row_ok;
			col_ok_s1 <= col_ok;
			orow_s1   <= emit_row_q;
			ocol_s1   <= emit_col_q;
		end
	end

	// Four line stores packed in one word per column; the newest row sits in the low byte.
	gblur_ram #(
		.WIDTH (LINES * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (v1_s1 && adv2),
		.waddr (col_s1),
		.wdata (line_wr),
		.re    (take && casc),
		.raddr (in_col_q),
		.rdata (line_rd)
	);

	// Age every stored row by one line and build the incoming window column.
	always_comb begin
		line_wr = {line_rd[(LINES-1)*PIX_W-1:0], pix_s1};
		col_new[TAPS-1] = pix_s1;
		for (int k = 0; k < LINES; k++) begin
			col_new[LINES-1-k] = line_rd[k*PIX_W +: PIX_W];
		end
	end

	// Stage 2: shift the window left by one column.
	always_ff @(posedge clk) begin
		if (adv2 && v1_s1) begin
			for (int dy = 0; dy < TAPS; dy++) begin
				for (int dx = 0; dx < TAPS - 1; dx++) begin
					win_s2[dy][dx] <= win_s2[dy][dx+1];
				end
				win_s2[dy][TAPS-1] <= col_new[dy];
			end
			row_ok_s2 <= row_ok_s1;
			col_ok_s2 <= col_ok_s1;
			orow_s2   <= orow_s1;
			ocol_s2   <= ocol_s1;
			done_s2   <= done_s1;
		end
	end

	// Weighted sum of each window row with the out-of-frame taps masked.
	always_comb begin
		for (int dy = 0; dy < TAPS; dy++) begin
			rowsum[dy] = '0;
			for (int dx = 0; dx < TAPS; dx++) begin
				if (row_ok_s2[dy] && col_ok_s2[dx]) begin
					rowsum[dy] = rowsum[dy] +
						ACC_W'(win_s2[dy][dx]) * ACC_W'(WEIGHT[dy][dx]);
				end
			end
		end
	end

	// Stage 3 payload.
	always_ff @(posedge clk) begin
		if (adv3 && v2_s2) begin
			rowsum_s3 <= rowsum;
			orow_s3   <= orow_s2;
			ocol_s3   <= ocol_s2;
			done_s3   <= done_s2;
		end
	end

	// Add the row sums, round to nearest and saturate to eight bits.
	always_comb begin
		total = ACC_W'(1) << (FRAC_W - 1);
		for (int dy = 0; dy < TAPS; dy++) begin
			total = total + rowsum_s3[dy];
		end
		scaled = total[ACC_W-1:FRAC_W];
		sat    = (32'(scaled) > PIX_MAX) ? PIX_W'(PIX_MAX) : scaled[PIX_W-1:0];
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ld_out) begin
			blur_q.blurred_pixel <= sat;
			blur_q.out_row       <= orow_s3;
			blur_q.out_col       <= ocol_s3;
			blur_q.frame_done    <= done_s3;
		end
	end

	assign blur_valid = out_valid_q;
	assign blur       = blur_q;

endmodule

`default_nettype wire

### design/gaussian_blur_5x5_checker.sv
// Port-level checker for the 5x5 Gaussian blur, bound to the top level.
// Depends on gblur_pkg and gaussian_blur_5x5_macros.svh.
`default_nettype none
`include "gaussian_blur_5x5_macros.svh"

module gaussian_blur_5x5_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pix_valid,
	input logic                 pix_ready,
	input logic                 blur_valid,
	input logic                 blur_ready,
	input gblur_pkg::blur_rsp_t blur
);
	import gblur_pkg::*;

	localparam int PEND_W = 16;

	logic [PEND_W-1:0] pend_q;
	logic              last_ok_q;
	logic [ROW_W-1:0]  last_row_q;
	logic [COL_W-1:0]  last_col_q;
	logic              req_take, rsp_take;

	assign req_take = pix_valid && pix_ready;
	assign rsp_take = blur_valid && blur_ready;

	// Requests taken minus results delivered; the count sticks once it saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pend_q != '1) begin
			pend_q <= pend_q + PEND_W'(req_take) - PEND_W'(rsp_take);
		end
	end

	// Position of the last delivered result inside the current frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ok_q  <= 1'b0;
			last_row_q <= '0;
			last_col_q <= '0;
		end else if (rsp_take) begin
			last_ok_q  <= !blur.frame_done;
			last_row_q <= blur.out_row;
			last_col_q <= blur.out_col;
		end
	end

	// A stalled result keeps its contents.
	`GB_ASSERT_NEXT(a_rsp_hold, blur_valid && !blur_ready, blur_valid && $stable(blur),
		"result changed while stalled")

	// Every result is backed by an earlier request.
	`GB_ASSERT_NOW(a_rsp_backed, blur_valid, pend_q != '0,
		"result without an outstanding request")

	// The last pixel of a frame is never in the first two rows or columns.
	`GB_ASSERT_NOW(a_done_pos, blur_valid && blur.frame_done,
		blur.out_row >= ROW_W'(2) && blur.out_col >= COL_W'(2),
		"frame end marked at an impossible position")

	// Within a row, results come in consecutive columns.
	`GB_ASSERT_NOW(a_raster, rsp_take && last_ok_q && blur.out_col != '0,
		blur.out_col == last_col_q + COL_W'(1) && blur.out_row == last_row_q,
		"results out of raster order")

endmodule

bind gaussian_blur_5x5 gaussian_blur_5x5_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_ready  (pix_ready),
	.blur_valid (blur_valid),
	.blur_ready (blur_ready),
	.blur       (blur)
);

`default_nettype wire

### bench/blur_checker.sv
// Checker for the 5x5 Gaussian blur: it watches the register port, the request and the
// result channels, predicts every blurred pixel and compares it on arrival.
// Depends on gblur_pkg for the payload structs, sizes and weight table.
`default_nettype none

module blur_checker
	import gblur_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	input  logic                 pix_ready,
	input  pix_req_t             pix,
	input  logic                 blur_valid,
	input  logic                 blur_ready,
	input  blur_rsp_t            blur,
	output int                   mismatches,
	output int                   waiting,
	output int                   checked,
	output int                   frames
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = LINES * MAX_WIDTH + TAPS;

	// Copies of the size registers and the sizes latched for the open frame.
	logic [CFG_W_W-1:0] reg_w;
	logic [CFG_H_W-1:0] reg_h;
	int                 line_w;
	int                 line_h;

	// Pixel history ring and the write and center positions.
	logic [PIX_W-1:0]   pixel_ring [RING_DEPTH];
	int                 wr_row;
	int                 wr_col;
	int                 ctr_row;
	int                 ctr_col;
	int                 flush_owed;

	blur_rsp_t          expected_blur [$];
	blur_rsp_t          want;

	// Weighted sum of the 5x5 neighborhood around the current center, then
	// step the center forward in raster order.
	function automatic blur_rsp_t blur_center(input bit last);
		blur_rsp_t res;
		int        acc;
		int        y;
		int        x;
		int        tap;
		acc = 0;
		for (int dy = 0; dy < TAPS; dy++) begin
			for (int dx = 0; dx < TAPS; dx++) begin
				y = ctr_row + dy - HALF;
				x = ctr_col + dx - HALF;
				tap = 0;
				if (y >= 0 && y < line_h && x >= 0 && x < line_w)
					tap = pixel_ring[(y * line_w + x) % (LINES * line_w + TAPS)];
				acc += tap * int'(WEIGHT[dy][dx]);
			end
		end
		acc = (acc + (1 << (FRAC_W - 1))) >> FRAC_W;
		res.blurred_pixel = (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(acc);
		res.out_row       = ROW_W'(ctr_row);
		res.out_col       = COL_W'(ctr_col);
		res.frame_done    = last;
		ctr_col++;
		if (ctr_col >= line_w) begin
			ctr_col = 0;
			ctr_row++;
		end
		return res;
	endfunction

	// Apply one accepted request to the predicted state.
	function automatic void predict_request(input pix_req_t req);
		int pos;
		// During the flush every request produces one of the owed pixels.
		if (flush_owed > 0) begin
			flush_owed--;
			expected_blur.push_back(blur_center(flush_owed == 0));
			if (flush_owed == 0) begin
				wr_row  = 0;
				wr_col  = 0;
				ctr_row = 0;
				ctr_col = 0;
				frames++;
			end
			return;
		end
		if (req.action == ACT_DRAIN)
			return;
		// The first pixel of a frame latches the clamped sizes.
		if (wr_row == 0 && wr_col == 0) begin
			line_w = (reg_w < MIN_SIZE) ? MIN_SIZE : (reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w;
			line_h = (reg_h < MIN_SIZE) ? MIN_SIZE : (reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h;
		end
		pos = wr_row * line_w + wr_col;
		pixel_ring[pos % (LINES * line_w + TAPS)] = req.pixel_value;
		wr_col++;
		if (wr_col >= line_w) begin
			wr_col = 0;
			wr_row++;
		end
		if (pos + 1 == line_w * line_h)
			flush_owed = 2 * line_w + 2;
		if (pos >= 2 * line_w + 2)
			expected_blur.push_back(blur_center(1'b0));
	endfunction

	// Track register writes and requests, and compare each delivered pixel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_w      = CFG_W_W'(RESET_FRAME_WIDTH);
			reg_h      = CFG_H_W'(RESET_FRAME_HEIGHT);
			line_w     = RESET_FRAME_WIDTH;
			line_h     = RESET_FRAME_HEIGHT;
			wr_row     = 0;
			wr_col     = 0;
			ctr_row    = 0;
			ctr_col    = 0;
			flush_owed = 0;
			mismatches = 0;
			checked    = 0;
			frames     = 0;
			expected_blur.delete();
			waiting <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FRAME_WIDTH:  reg_w = cfg_data[CFG_W_W-1:0];
					REG_FRAME_HEIGHT: reg_h = cfg_data[CFG_H_W-1:0];
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				predict_request(pix);
			if (blur_valid && blur_ready) begin
				if (expected_blur.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: blurred pixel with none pending: pixel %0d row %0d col %0d done %0d",
							$realtime, blur.blurred_pixel, blur.out_row, blur.out_col,
							blur.frame_done);
				end else begin
					want = expected_blur.pop_front();
					checked++;
					if (blur.blurred_pixel !== want.blurred_pixel || blur.out_row !== want.out_row ||
							blur.out_col !== want.out_col || blur.frame_done !== want.frame_done) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: mismatch: want pixel %0d row %0d col %0d done %0d, got pixel %0d row %0d col %0d done %0d",
								$realtime, want.blurred_pixel, want.out_row, want.out_col,
								want.frame_done, blur.blurred_pixel, blur.out_row, blur.out_col,
								blur.frame_done);
					end
				end
			end
			waiting <= expected_blur.size();
		end
	end

endmodule

`default_nettype wire

### bench/tb_top.sv
// Top of the 5x5 Gaussian blur testbench: clock, reset, frame stimulus and
// output back-pressure around the block, with blur_checker alongside.
// Depends on gblur_pkg, gaussian_blur_5x5 and blur_checker.
`default_nettype none

module tb_top;
	import gblur_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles to let the pipeline empty after the last expected pixel.
	localparam int SETTLE      = 16;
	localparam int ITEM_TARGET = 1400;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx    = '0;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 pix_valid  = 1'b0;
	logic                 pix_ready;
	pix_req_t             pix        = '0;
	logic                 blur_valid;
	logic                 blur_ready = 1'b0;
	blur_rsp_t            blur;

	int mismatches;
	int waiting;
	int checked;
	int frames;

	int gap_odds   = 0;
	int stall_odds = 0;
	int stall_left = 0;
	int eff_w      = RESET_FRAME_WIDTH;
	int eff_h      = RESET_FRAME_HEIGHT;
	int sent       = 0;
	bit carry;

	gaussian_blur_5x5 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.blur_valid(blur_valid),
		.blur_ready(blur_ready),
		.blur      (blur)
	);

	blur_checker check_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.blur_valid(blur_valid),
		.blur_ready(blur_ready),
		.blur      (blur),
		.mismatches(mismatches),
		.waiting   (waiting),
		.checked   (checked),
		.frames    (frames)
	);

	always #5 clk = ~clk;

	// Output back-pressure: random stalls that hold blur_ready low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			blur_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_odds != 0 && $urandom_range(stall_odds - 1) == 0) begin
			blur_ready <= 1'b0;
			stall_left <= $urandom_range(9);
		end else begin
			blur_ready <= 1'b1;
		end
	end

	// Present one request, with an occasional idle burst before it, and hold
	// it until the block takes it.
	task automatic send_request(input logic act, input logic [PIX_W-1:0] value);
		if (gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= '{action: act, pixel_value: value};
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
	endtask

	// Stop sending until every predicted pixel has arrived and the pipeline
	// has had time to empty.
	task automatic wait_idle();
		pix_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both size registers and note the sizes the next frame will use.
	task automatic set_frame(input int unsigned w_raw, input int unsigned h_raw);
		int w_fld;
		int h_fld;
		w_fld = w_raw & ((1 << CFG_W_W) - 1);
		h_fld = h_raw & ((1 << CFG_H_W) - 1);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_FRAME_WIDTH;
		cfg_data <= CFG_W'(w_raw);
		@(posedge clk);
		cfg_idx  <= REG_FRAME_HEIGHT;
		cfg_data <= CFG_W'(h_raw);
		@(posedge clk);
		cfg_we   <= 1'b0;
		eff_w = (w_fld < MIN_SIZE) ? MIN_SIZE : (w_fld > MAX_WIDTH) ? MAX_WIDTH : w_fld;
		eff_h = (h_fld < MIN_SIZE) ? MIN_SIZE : (h_fld > MAX_HEIGHT) ? MAX_HEIGHT : h_fld;
	endtask

	// Small random sizes; some below the minimum, some with junk above the
	// width field.
	task automatic pick_frame();
		int unsigned w_raw;
		int unsigned h_raw;
		case ($urandom_range(7))
			0:       w_raw = $urandom_range(2);
			1:       w_raw = ($urandom_range(1, 7) << CFG_W_W) | $urandom_range(3, 12);
			default: w_raw = $urandom_range(3, 12);
		endcase
		h_raw = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
		set_frame(w_raw, h_raw);
	endtask

	// One whole frame followed by its flush. Stray drains before and inside
	// the frame are ignored; pixels mixed into the flush act as drains.
	task automatic run_frame(input bit retune);
		int fw;
		int fh;
		int npix;
		int tone;
		logic [PIX_W-1:0] value;
		fw   = eff_w;
		fh   = eff_h;
		npix = fw * fh;
		tone = $urandom_range(3);
		if ($urandom_range(2) == 0)
			send_request(ACT_DRAIN, PIX_W'($urandom));
		for (int k = 0; k < npix; k++) begin
			// Sizes written mid-frame only apply from the next frame on.
			if (retune && k == npix / 2) begin
				wait_idle();
				pick_frame();
			end
			if ($urandom_range(40) == 0)
				send_request(ACT_DRAIN, PIX_W'($urandom));
			case (tone)
				0:       value = PIX_W'($urandom_range(240, 255));
				1:       value = PIX_W'($urandom_range(15));
				default: value = PIX_W'($urandom);
			endcase
			send_request(ACT_PIXEL, value);
		end
		for (int k = 0; k < 2 * fw + 2; k++)
			send_request(($urandom_range(3) == 0) ? ACT_PIXEL : ACT_DRAIN, PIX_W'($urandom));
		if ($urandom_range(2) == 0)
			send_request(ACT_DRAIN, PIX_W'($urandom));
		sent += npix + 2 * fw + 2;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a drain with no frame open, a saturated 3x3 frame and a
		// pixel arriving in the middle of its flush.
		set_frame(3, 3);
		send_request(ACT_DRAIN, '1);
		for (int k = 0; k < 9; k++)
			send_request(ACT_PIXEL, '1);
		for (int k = 0; k < 8; k++)
			send_request((k == 3) ? ACT_PIXEL : ACT_DRAIN, '0);
		wait_idle();

		// Random small frames with varying idle and stall rates.
		carry = 1'b0;
		while (sent < ITEM_TARGET) begin
			case ($urandom_range(3))
				0:       gap_odds = 0;
				1:       gap_odds = 2;
				2:       gap_odds = 6;
				default: gap_odds = 15;
			endcase
			case ($urandom_range(3))
				0:       stall_odds = 0;
				1:       stall_odds = 2;
				2:       stall_odds = 6;
				default: stall_odds = 15;
			endcase
			if (!carry)
				pick_frame();
			carry = ($urandom_range(5) == 0);
			run_frame(carry);
			wait_idle();
		end

		// From here on no idling: a few small frames back to back, with the
		// block drained before each size write.
		gap_odds   = 0;
		stall_odds = 0;
		repeat (3) begin
			pick_frame();
			run_frame(1'b0);
			wait_idle();
		end

		$display("Checked %0d blurred pixels over %0d frames, %0d mismatches.",
			checked, frames, mismatches);
		$display("Frames of 3x3 up to 12x10, with clamped sizes and mid-frame writes.");
		if (mismatches == 0 && waiting == 0) begin
			$display("[gaussian_blur_5x5] OK");
		end else begin
			$display("[gaussian_blur_5x5] ERROR");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5_000_000;
		$display("[gaussian_blur_5x5] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
